[hw/rtl/s1a_pkg.sv]
// shared types, key codes and us-layout tables for the scancode translator
`timescale 1ns / 1ps
`default_nettype none

package s1a_pkg;

    localparam int unsigned SCAN_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned MAP_AW  = 6;
    localparam int unsigned MAP_N   = 64;

    // set 1 make codes with special handling
    localparam logic [SCAN_W-2:0] KEY_LSHIFT   = 7'h2A;
    localparam logic [SCAN_W-2:0] KEY_RSHIFT   = 7'h36;
    localparam logic [SCAN_W-2:0] KEY_CAPSLOCK = 7'h3A;

    // bit position of the release flag
    localparam int unsigned REL_BIT = SCAN_W - 1;

    // ascii letter bounds and the case bit
    localparam logic [CHAR_W-1:0] CHR_LO_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHR_LO_Z = 7'h7A;
    localparam int unsigned       CASE_BIT = 5;

    typedef logic [CHAR_W-1:0] t_char;

    // result of translating one item against the current flags
    typedef struct packed {
        logic  emit;
        t_char ch;
        logic  shift_nxt;
        logic  caps_nxt;
    } t_xlate;

    localparam t_char PLAIN_MAP [MAP_N] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam t_char UPPER_MAP [MAP_N] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

`default_nettype wire

[hw/rtl/s1a_xlate.sv]
// combinational translation of one scancode byte and flag update
`timescale 1ns / 1ps
`default_nettype none

module s1a_xlate (
    input  wire logic [s1a_pkg::SCAN_W-1:0] i_scan_byte,
    input  wire logic                       i_shift,
    input  wire logic                       i_caps,
    output s1a_pkg::t_xlate                 o_res
);

    logic [s1a_pkg::SCAN_W-2:0] key;
    logic                       is_shift;
    s1a_pkg::t_char             raw_ch;
    s1a_pkg::t_char             folded;

    assign key      = i_scan_byte[s1a_pkg::SCAN_W-2:0];
    assign is_shift = (key == s1a_pkg::KEY_LSHIFT) || (key == s1a_pkg::KEY_RSHIFT);

    // table pick by shift state
    assign raw_ch = i_shift ? s1a_pkg::UPPER_MAP[i_scan_byte[s1a_pkg::MAP_AW-1:0]]
                            : s1a_pkg::PLAIN_MAP[i_scan_byte[s1a_pkg::MAP_AW-1:0]];

    // letters only: lower-cased copy in range a..z means a letter of either case
    always_comb begin
        folded = raw_ch | s1a_pkg::CHAR_W'(1 << s1a_pkg::CASE_BIT);
    end

    always_comb begin
        o_res.emit      = 1'b0;
        o_res.ch        = raw_ch;
        o_res.shift_nxt = i_shift;
        o_res.caps_nxt  = i_caps;
        priority if (i_scan_byte[s1a_pkg::REL_BIT]) begin
            if (is_shift) begin
                o_res.shift_nxt = 1'b0;
            end
        end else if (is_shift) begin
            o_res.shift_nxt = 1'b1;
        end else if (key == s1a_pkg::KEY_CAPSLOCK) begin
            o_res.caps_nxt = ~i_caps;
        end else if (i_scan_byte[s1a_pkg::MAP_AW]) begin
            o_res.emit = 1'b0;
        end else begin
            o_res.emit = (raw_ch != '0);
            if (i_caps && (folded >= s1a_pkg::CHR_LO_A) && (folded <= s1a_pkg::CHR_LO_Z)) begin
                o_res.ch = raw_ch ^ s1a_pkg::CHAR_W'(1 << s1a_pkg::CASE_BIT);
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/scancode_set1_to_ascii.sv]
// top level: scancode set 1 to ascii translator, us layout
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel: i_valid / o_stall / i_scan_byte, one raw set 1 byte per item
//   output channel: o_valid / i_stall / o_ascii_char, zero or one char per input item
//   an item is taken on a rising edge with valid high and stall low
// structure
//   input register -> table lookup and flag update -> result register
//   shift and caps lock flags update as an item leaves the input register
// flow
//   a byte taken goes to the input register; its char, if any, is loaded into
//   the result register when the item advances, which a stalled result delays
// throughput
//   one item per cycle if unstalled, set by the single lookup stage between registers
// reset
//   synchronous, active low; both stages empty, shift and caps lock off
// stall
//   a stalled result holds; the input register keeps filling behind it and
//   o_stall rises only once both stages hold an item that cannot move
module scancode_set1_to_ascii (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [s1a_pkg::SCAN_W-1:0]    i_scan_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [s1a_pkg::CHAR_W-1:0]    o_ascii_char
);

    // input stage
    logic                       r_in_valid;
    logic [s1a_pkg::SCAN_W-1:0] r_in_byte;

    // keyboard flags
    logic r_shift;
    logic r_caps;

    // result stage
    logic           r_out_valid;
    s1a_pkg::t_char r_out_char;

    s1a_pkg::t_xlate xl;
    logic            out_ready;
    logic            advance;
    logic            in_take;

    // result register can load when empty or when its item leaves now
    assign out_ready = !r_out_valid || !i_stall;
    // item in the input register is translated and retired this cycle
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_take   = i_valid && !o_stall;

    s1a_xlate u_xlate (
        .i_scan_byte (r_in_byte),
        .i_shift     (r_shift),
        .i_caps      (r_caps),
        .o_res       (xl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= advance && xl.emit;
            end
            if (advance) begin
                r_shift <= xl.shift_nxt;
                r_caps  <= xl.caps_nxt;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_scan_byte;
        end
        if (advance && xl.emit) begin
            r_out_char <= xl.ch;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;

`ifndef SYNTH
    // a delivered char is never the empty table entry
    a_no_zero_char : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char != '0))
        else $error("result register holds a zero char");

    // a release byte never produces a char
    a_release_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte[s1a_pkg::REL_BIT]) |=> !r_out_valid)
        else $error("release byte produced a char");

    // shift press sets the shift flag
    a_shift_set : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_byte[s1a_pkg::REL_BIT]
         && (r_in_byte[s1a_pkg::SCAN_W-2:0] == s1a_pkg::KEY_LSHIFT
             || r_in_byte[s1a_pkg::SCAN_W-2:0] == s1a_pkg::KEY_RSHIFT))
        |=> r_shift)
        else $error("shift press did not set shift flag");

    // caps lock press toggles the caps flag
    a_caps_toggle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_byte[s1a_pkg::REL_BIT]
         && r_in_byte[s1a_pkg::SCAN_W-2:0] == s1a_pkg::KEY_CAPSLOCK)
        |=> (r_caps != $past(r_caps)))
        else $error("caps lock press did not toggle caps flag");

    // flags only move when an item retires
    a_flags_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_shift) && $stable(r_caps)))
        else $error("keyboard flags changed without an item");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the set 1 scancode to ascii translator
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned SCAN_W = s1a_pkg::SCAN_W;
    localparam int unsigned CHAR_W = s1a_pkg::CHAR_W;

    // make codes with special meaning, plus a few plain keys for the directed part
    localparam logic [SCAN_W-1:0] SC_SHF_LEFT  = 8'h2A;
    localparam logic [SCAN_W-1:0] SC_SHF_RIGHT = 8'h36;
    localparam logic [SCAN_W-1:0] SC_CAPS    = 8'h3A;
    localparam logic [SCAN_W-1:0] SC_RELEASE = 8'h80;
    localparam logic [SCAN_W-1:0] SC_PRE_E0  = 8'hE0;
    localparam logic [SCAN_W-1:0] SC_PRE_E1  = 8'hE1;
    localparam logic [SCAN_W-1:0] SC_1       = 8'h02;
    localparam logic [SCAN_W-1:0] SC_BKSP    = 8'h0E;
    localparam logic [SCAN_W-1:0] SC_Q       = 8'h10;
    localparam logic [SCAN_W-1:0] SC_ENTER   = 8'h1C;
    localparam logic [SCAN_W-1:0] SC_A       = 8'h1E;
    localparam logic [SCAN_W-1:0] SC_SEMI    = 8'h27;
    localparam logic [SCAN_W-1:0] SC_SPACE   = 8'h39;
    localparam logic [SCAN_W-1:0] SC_HOLE_LO = 8'h40;
    localparam logic [SCAN_W-1:0] SC_HOLE_HI = 8'h7F;
    localparam logic [SCAN_W-1:0] SC_MIN     = 8'h00;
    localparam logic [SCAN_W-1:0] SC_MAX     = 8'hFF;
    localparam int unsigned       KEY_SPAN   = 64;

    // ascii letter bounds for the caps lock case flip
    localparam logic [CHAR_W-1:0] ASC_LO_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASC_LO_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] ASC_UP_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASC_UP_Z = 7'h5A;

    // run shape
    localparam int unsigned ITEM_TARGET  = 1500;
    localparam int unsigned MAX_IDLE     = 11;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned PRINT_LIMIT  = 50;

    // us layout, no shift
    localparam logic [CHAR_W-1:0] PLAIN_KEYS [KEY_SPAN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // us layout, shift held
    localparam logic [CHAR_W-1:0] SHIFTED_KEYS [KEY_SPAN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // block ports, inputs all known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic [SCAN_W-1:0] i_scan_byte = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [CHAR_W-1:0] o_ascii_char;

    // bytes waiting to be sent and chars waiting to come back
    logic [SCAN_W-1:0] pending_bytes[$];
    logic [CHAR_W-1:0] expected_chars[$];

    // predictor copy of the keyboard flags
    bit pred_shift;
    bit pred_caps;

    // sender and receiver pacing
    int unsigned send_wait;
    bit          send_quiet;
    int unsigned recv_wait;
    int unsigned hold_left;
    bit          recv_quiet;
    int unsigned chars_taken;
    logic [CHAR_W-1:0] want_char;

    int unsigned mismatch_count;
    int unsigned stuck_cycles;
    int unsigned byte_count;

    scancode_set1_to_ascii dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_scan_byte  (i_scan_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // update the flags for one accepted byte and queue the char it should give
    task automatic translate_key(input logic [SCAN_W-1:0] code);
        logic [SCAN_W-2:0] key;
        logic [CHAR_W-1:0] ch;
        key = code[SCAN_W-2:0];
        if (code[SCAN_W-1]) begin
            // only a shift release matters, caps lock and prefixes fall through
            if (key == SC_SHF_LEFT[SCAN_W-2:0] || key == SC_SHF_RIGHT[SCAN_W-2:0]) begin
                pred_shift = 1'b0;
            end
        end else if (code == SC_SHF_LEFT || code == SC_SHF_RIGHT) begin
            pred_shift = 1'b1;
        end else if (code == SC_CAPS) begin
            pred_caps = !pred_caps;
        end else if (code < KEY_SPAN) begin
            ch = pred_shift ? SHIFTED_KEYS[code[5:0]] : PLAIN_KEYS[code[5:0]];
            if (ch != '0) begin
                // caps lock flips letter case only, on top of shift
                if (pred_caps && ((ch >= ASC_LO_A && ch <= ASC_LO_Z) ||
                                  (ch >= ASC_UP_A && ch <= ASC_UP_Z))) begin
                    ch[5] = ~ch[5];
                end
                expected_chars.push_back(ch);
            end
        end
    endtask

    task automatic queue_byte(input logic [SCAN_W-1:0] code);
        pending_bytes.push_back(code);
        byte_count++;
    endtask

    // random well-formed typing with some noise mixed in
    task automatic queue_random_typing();
        int unsigned kind;
        int unsigned n;
        logic [SCAN_W-1:0] key;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            // plain key press, often followed by its release
            key = 8'($urandom_range(0, KEY_SPAN - 1));
            queue_byte(key);
            if ($urandom_range(0, 1) == 1) begin
                queue_byte(key | SC_RELEASE);
            end
        end else if (kind < 70) begin
            // shifted burst on either shift key
            key = ($urandom_range(0, 1) == 1) ? SC_SHF_LEFT : SC_SHF_RIGHT;
            queue_byte(key);
            n = $urandom_range(1, 6);
            repeat (n) queue_byte(8'($urandom_range(0, KEY_SPAN - 1)));
            // sometimes release the other shift key, which still clears the flag
            if ($urandom_range(0, 3) == 0) begin
                key = (key == SC_SHF_LEFT) ? SC_SHF_RIGHT : SC_SHF_LEFT;
            end
            queue_byte(key | SC_RELEASE);
        end else if (kind < 76) begin
            queue_byte(SC_CAPS);
            if ($urandom_range(0, 1) == 1) begin
                queue_byte(SC_CAPS | SC_RELEASE);
            end
        end else if (kind < 86) begin
            // any byte at all
            queue_byte(8'($urandom_range(0, 255)));
        end else if (kind < 93) begin
            // extended prefix, then a byte taken as an ordinary code
            queue_byte(($urandom_range(0, 1) == 1) ? SC_PRE_E0 : SC_PRE_E1);
            queue_byte(8'($urandom_range(0, 255)));
        end else begin
            // stray release of a random key, which may also clear shift
            queue_byte(8'($urandom_range(0, KEY_SPAN - 1)) | SC_RELEASE);
        end
    endtask

    // driver: offers the next byte once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            send_wait  = 0;
            send_quiet = 1'b0;
            pred_shift = 1'b0;
            pred_caps  = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                translate_key(i_scan_byte);
            end
            // a stalled item holds still
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    i_valid     <= 1'b1;
                    i_scan_byte <= pending_bytes.pop_front();
                    // gap after this item; quiet stretches send back to back
                    if ($urandom_range(0, 49) == 0) begin
                        send_quiet = !send_quiet;
                    end
                    send_wait = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each char taken and paces the result stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            recv_wait   = 0;
            hold_left   = 0;
            recv_quiet  = 1'b0;
            chars_taken = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h with none expected", o_ascii_char));
                end else begin
                    want_char = expected_chars.pop_front();
                    if (o_ascii_char !== want_char) begin
                        report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                                  o_ascii_char, want_char));
                    end
                end
                chars_taken++;
                if ($urandom_range(0, 39) == 0) begin
                    recv_quiet = !recv_quiet;
                end
                recv_wait = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
                // long hold-off twice so both stages fill and the input backs up
                if (chars_taken == 60 || chars_taken == 500) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no traffic on either side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles = 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // directed: field extremes, shift, caps lock, prefixes, holes in the table
        queue_byte(SC_MIN);                 // unmapped, nothing out
        queue_byte(SC_MAX);                 // release of an unmapped key
        queue_byte(SC_Q);
        queue_byte(SC_1);
        queue_byte(SC_SHF_LEFT);
        queue_byte(SC_Q);                   // shifted letter
        queue_byte(SC_1);                   // shifted digit
        queue_byte(SC_SHF_LEFT | SC_RELEASE);
        queue_byte(SC_SHF_RIGHT);
        queue_byte(SC_A);
        queue_byte(SC_SHF_RIGHT | SC_RELEASE);
        queue_byte(SC_CAPS);                // caps lock on
        queue_byte(SC_CAPS | SC_RELEASE);   // caps release ignored
        queue_byte(SC_A);                   // letter flipped to upper
        queue_byte(SC_1);                   // digit untouched by caps lock
        queue_byte(SC_SHF_LEFT);
        queue_byte(SC_A);                   // shift plus caps gives lower
        queue_byte(SC_SEMI);                // shifted punctuation untouched
        queue_byte(SC_SHF_LEFT | SC_RELEASE);
        queue_byte(SC_HOLE_LO);
        queue_byte(SC_HOLE_HI);
        queue_byte(SC_PRE_E0);              // prefix taken as a plain release
        queue_byte(SC_BKSP);
        queue_byte(SC_ENTER);
        queue_byte(SC_SPACE);
        queue_byte(SC_CAPS);                // caps lock back off
        while (byte_count < ITEM_TARGET) begin
            queue_random_typing();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every byte is taken and every char has come back,
        // sampled mid-cycle once the edge updates have settled
        do begin
            @(negedge i_clk);
        end while (pending_bytes.size() != 0 || i_valid || expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
